// ----- design/clrs_pkg.sv -----
// Shared types, codes and constants of the crash loop restart supervisor.
package clrs_pkg;

   localparam int FAIL_DEPTH_DEF = 16;
   localparam int TIME_BITS_DEF  = 32;

   localparam int OP_W       = 4;
   localparam int TIME_W     = 32;
   localparam int SESS_W     = 32;
   localparam int BOOT_W     = 64;
   localparam int PHASE_W    = 3;
   localparam int CFG_W      = 20;
   localparam int LIMIT_W    = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CFG_W-1:0]   RESTART_DELAY_RST = 20'd5;
   localparam logic [LIMIT_W-1:0] FAILURE_LIMIT_RST = 5'd3;
   localparam logic [CFG_W-1:0]   FAILURE_WINDOW_RST = 20'd600;
   localparam logic [CFG_W-1:0]   BACKOFF_RST = 20'd900;
   localparam logic [CFG_W-1:0]   HEALTHY_RESET_RST = 20'd600;

   typedef enum logic [OP_W-1:0] {
      OP_USER_AVAIL = 4'd0,
      OP_READY      = 4'd1,
      OP_HEARTBEAT  = 4'd2,
      OP_CLEAN_OUT  = 4'd3,
      OP_RESUME     = 4'd4,
      OP_EXIT       = 4'd5,
      OP_LOGOFF     = 4'd6,
      OP_BOOT_CHG   = 4'd7,
      OP_QUERY      = 4'd8
   } op_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_WAIT    = 3'd0,
      PH_START   = 3'd1,
      PH_RUN     = 3'd2,
      PH_RWAIT   = 3'd3,
      PH_BACKOFF = 3'd4,
      PH_SUPP    = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_PRUNE,
      SEQ_APPEND,
      SEQ_DECIDE,
      SEQ_RESP
   } seq_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RESTART_DELAY  = 3'd0,
      CSR_FAILURE_LIMIT  = 3'd1,
      CSR_FAILURE_WINDOW = 3'd2,
      CSR_BACKOFF        = 3'd3,
      CSR_HEALTHY_RESET  = 3'd4,
      CSR_INIT_SUPP      = 3'd5,
      CSR_INIT_SUPP_SESS = 3'd6,
      CSR_INIT_SUPP_BOOT = 3'd7
   } csr_type;

   // flags from the shared time unit
   typedef struct packed {
      logic ge;      // a >= b
      logic age_le;  // age of b at a <= threshold
      logic age_ge;  // age of b at a >= threshold
   } tunit_flags_type;

endpackage

// ----- design/clrs_ring.sv -----
// Failure time ring: one write port, one registered read port.
module clrs_ring import clrs_pkg::*; #(
   parameter int DEPTH = FAIL_DEPTH_DEF,
   parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int DW    = TIME_W
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/clrs_tunit.sv -----
// Shared time unit: one adder doing age checks, compares and adds (saturating when TIME_BITS <= TIME_W).
module clrs_tunit import clrs_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF,
   localparam int TW = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W,
   localparam int RA_W = TW + 1
) (
   input  logic            sub,
   input  logic [RA_W-1:0] a,
   input  logic [RA_W-1:0] b,
   input  logic [CFG_W-1:0] thr,
   output tunit_flags_type flags,
   output logic [RA_W-1:0] sum
);

   localparam int CMP_W = (RA_W > CFG_W) ? RA_W : CFG_W;
   localparam bit SAT_EN = (TIME_BITS <= TIME_W);

   logic [RA_W:0]   res;
   logic            borrow;
   logic [RA_W-1:0] age;

   always_comb begin
      res = {1'b0, a} + ({1'b0, b} ^ {(RA_W+1){sub}}) + (RA_W+1)'(sub);
      borrow = res[RA_W];
      // a clock that seems to run backwards gives an age of zero
      age = borrow ? '0 : res[RA_W-1:0];
      flags.ge     = !borrow;
      flags.age_le = CMP_W'(age) <= CMP_W'(thr);
      flags.age_ge = CMP_W'(age) >= CMP_W'(thr);
      if (SAT_EN && res[TW]) begin
         sum = {1'b0, {TW{1'b1}}};
      end else begin
         sum = res[RA_W-1:0];
      end
   end

endmodule

// ----- design/crash_loop_restart_supervisor_core.sv -----
// Crash loop restart supervisor: sequencer, state and configuration registers.
// An accepted item passes EXEC and RESP, which registers the result strobe; an exit that is not a
// clean one under suppression also passes PRUNE, APPEND and DECIDE; PRUNE grows with the failures
// on record (at most MAX_FAILURES), as the ring is pruned one entry a cycle through its single read
// port and the time unit. busy falls with the strobe, and start is ignored while busy.
// Reset (synchronous): configuration to defaults, waiting phase, no suppression,
// empty failure ring. The receiver cannot stall; each result shows for one cycle.
module crash_loop_restart_supervisor_core import clrs_pkg::*; #(
   parameter int MAX_FAILURES = FAIL_DEPTH_DEF,
   parameter int TIME_BITS    = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_op,
   input  logic [TIME_W-1:0]     req_time_now,
   input  logic [SESS_W-1:0]     req_session,
   input  logic [BOOT_W-1:0]     req_boot_epoch,
   input  logic                  req_clean_exit,
   output logic                  rsp_valid,
   output logic [PHASE_W-1:0]    rsp_phase,
   output logic                  rsp_start_request,
   output logic [TIME_W-1:0]     rsp_restart_time,
   output logic                  rsp_supp_active,
   output logic [SESS_W-1:0]     rsp_supp_session_out,
   output logic [BOOT_W-1:0]     rsp_supp_boot_out,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int TW   = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
   localparam int RA_W = TW + 1;
   localparam int CW   = $clog2(MAX_FAILURES + 1);
   localparam int IW   = (MAX_FAILURES > 1) ? $clog2(MAX_FAILURES) : 1;
   localparam int LW   = (CW > LIMIT_W) ? CW : LIMIT_W;

   function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= (CW+1)'(MAX_FAILURES)) begin
         s = s - (CW+1)'(MAX_FAILURES);
      end
      return IW'(s);
   endfunction

   // configuration
   logic [CFG_W-1:0]   restart_delay_ff, failure_window_ff, backoff_ff, healthy_reset_ff;
   logic [LIMIT_W-1:0] failure_limit_ff;

   // sequencer and held item
   seq_type            state_ff, state_in;
   op_type             op_ff;
   logic [TW-1:0]      now_ff;
   logic [SESS_W-1:0]  sess_ff;
   logic [BOOT_W-1:0]  boot_ff;
   logic               clean_ff;

   // supervisor state
   phase_type          phase_ff, phase_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      oldest_ff, oldest_in;
   logic [TW-1:0]      ready_time_ff, ready_time_in;
   logic               ready_valid_ff, ready_valid_in;
   logic [RA_W-1:0]    restart_at_ff, restart_at_in;
   logic [BOOT_W-1:0]  live_boot_ff, live_boot_in;
   logic               supp_ff, supp_in;
   logic [SESS_W-1:0]  supp_sess_ff, supp_sess_in;
   logic [BOOT_W-1:0]  supp_boot_ff, supp_boot_in;

   // pruning pass
   logic [CW-1:0]      rd_i_ff, rd_i_in;
   logic [CW-1:0]      kept_ff, kept_in;
   logic               pend_ff, pend_in;

   logic               launch_ff, launch_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // ring and time unit hookup
   logic               wr_en, rd_en;
   logic [IW-1:0]      wr_addr, rd_addr;
   logic [TW-1:0]      wr_data, rd_data;
   logic               u_sub;
   logic [RA_W-1:0]    u_a, u_b, u_sum;
   logic [CFG_W-1:0]   u_thr;
   tunit_flags_type    u_flags;
   logic               accept;

   assign accept    = start && (state_ff == SEQ_IDLE);
   assign busy      = (state_ff != SEQ_IDLE);
   assign csr_ready = 1'b1;

   clrs_ring #(.DEPTH(MAX_FAILURES), .IW(IW), .DW(TW)) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   clrs_tunit #(.TIME_BITS(TIME_BITS)) u_tunit (
      .sub   (u_sub),
      .a     (u_a),
      .b     (u_b),
      .thr   (u_thr),
      .flags (u_flags),
      .sum   (u_sum)
   );

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      count_in       = count_ff;
      oldest_in      = oldest_ff;
      ready_time_in  = ready_time_ff;
      ready_valid_in = ready_valid_ff;
      restart_at_in  = restart_at_ff;
      live_boot_in   = live_boot_ff;
      supp_in        = supp_ff;
      supp_sess_in   = supp_sess_ff;
      supp_boot_in   = supp_boot_ff;
      rd_i_in        = rd_i_ff;
      kept_in        = kept_ff;
      pend_in        = 1'b0;
      launch_in      = launch_ff;
      rsp_valid_in   = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = ring_add(oldest_ff, kept_ff);
      wr_data        = rd_data;
      rd_en          = 1'b0;
      rd_addr        = ring_add(oldest_ff, rd_i_ff);
      u_sub          = 1'b1;
      u_a            = RA_W'(now_ff);
      u_b            = restart_at_ff;
      u_thr          = failure_window_ff;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               state_in = SEQ_EXEC;
            end
         end
         SEQ_EXEC: begin
            u_b      = RA_W'(ready_time_ff);
            u_thr    = healthy_reset_ff;
            state_in = SEQ_RESP;
            unique case (op_ff)
               OP_USER_AVAIL: begin
                  live_boot_in = boot_ff;
                  if (supp_ff && supp_sess_ff == sess_ff && supp_boot_ff == boot_ff) begin
                     phase_in = PH_SUPP;
                  end else begin
                     supp_in      = 1'b0;
                     supp_sess_in = '0;
                     supp_boot_in = '0;
                     if (phase_ff == PH_WAIT || phase_ff == PH_SUPP) begin
                        phase_in = PH_START;
                     end
                  end
               end
               OP_READY: begin
                  ready_time_in  = now_ff;
                  ready_valid_in = 1'b1;
                  phase_in       = PH_RUN;
               end
               OP_HEARTBEAT: begin
                  if (phase_ff == PH_START) begin
                     phase_in = PH_RUN;
                  end else if (phase_ff == PH_RUN && ready_valid_ff && u_flags.age_ge) begin
                     count_in  = '0;
                     oldest_in = '0;
                  end
                  ready_time_in  = now_ff;
                  ready_valid_in = 1'b1;
               end
               OP_CLEAN_OUT: begin
                  supp_in      = 1'b1;
                  supp_sess_in = sess_ff;
                  supp_boot_in = boot_ff;
                  phase_in     = PH_SUPP;
               end
               OP_RESUME: begin
                  supp_in      = 1'b0;
                  supp_sess_in = '0;
                  supp_boot_in = '0;
                  live_boot_in = boot_ff;
                  phase_in     = PH_START;
               end
               OP_EXIT: begin
                  if (clean_ff && supp_ff) begin
                     phase_in = PH_SUPP;
                  end else begin
                     supp_in      = 1'b0;
                     supp_sess_in = '0;
                     supp_boot_in = '0;
                     rd_i_in      = '0;
                     kept_in      = '0;
                     state_in     = SEQ_PRUNE;
                  end
               end
               OP_LOGOFF: begin
                  if (supp_sess_ff == sess_ff) begin
                     supp_in      = 1'b0;
                     supp_sess_in = '0;
                     supp_boot_in = '0;
                  end
                  phase_in = PH_WAIT;
               end
               OP_BOOT_CHG: begin
                  if (live_boot_ff != boot_ff) begin
                     supp_in      = 1'b0;
                     supp_sess_in = '0;
                     supp_boot_in = '0;
                  end
                  live_boot_in = boot_ff;
               end
               default: begin
               end
            endcase
         end
         SEQ_PRUNE: begin
            // reads run one ahead of the age checks; survivors are packed down
            u_b   = RA_W'(rd_data);
            u_thr = failure_window_ff;
            if (rd_i_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_i_in = rd_i_ff + CW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff && u_flags.age_le) begin
               wr_en   = 1'b1;
               kept_in = kept_ff + CW'(1);
            end
            // last entry is checked in the same cycle the pass ends
            if (rd_i_ff == count_ff) begin
               state_in = SEQ_APPEND;
            end
         end
         SEQ_APPEND: begin
            wr_en   = 1'b1;
            wr_data = now_ff;
            if (kept_ff == CW'(MAX_FAILURES)) begin
               // ring full: overwrite the oldest
               wr_addr   = oldest_ff;
               oldest_in = ring_add(oldest_ff, CW'(1));
               count_in  = kept_ff;
            end else begin
               count_in = kept_ff + CW'(1);
            end
            state_in = SEQ_APPEND == state_ff ? SEQ_DECIDE : state_ff;
         end
         SEQ_DECIDE: begin
            u_sub = 1'b0;
            if (LW'(count_ff) >= LW'(failure_limit_ff)) begin
               u_b      = RA_W'(backoff_ff);
               phase_in = PH_BACKOFF;
            end else begin
               u_b      = RA_W'(restart_delay_ff);
               phase_in = PH_RWAIT;
            end
            restart_at_in = u_sum;
            state_in      = SEQ_RESP;
         end
         SEQ_RESP: begin
            launch_in = (phase_ff == PH_START) ||
                        ((phase_ff == PH_RWAIT || phase_ff == PH_BACKOFF) && u_flags.ge);
            rsp_valid_in = 1'b1;
            state_in     = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= SEQ_IDLE;
         phase_ff          <= PH_WAIT;
         count_ff          <= '0;
         oldest_ff         <= '0;
         ready_time_ff     <= '0;
         ready_valid_ff    <= 1'b0;
         restart_at_ff     <= '0;
         live_boot_ff      <= '0;
         // no snapshot is restored at reset: suppression starts cleared
         supp_ff           <= 1'b0;
         supp_sess_ff      <= '0;
         supp_boot_ff      <= '0;
         rd_i_ff           <= '0;
         kept_ff           <= '0;
         pend_ff           <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         restart_delay_ff  <= RESTART_DELAY_RST;
         failure_limit_ff  <= FAILURE_LIMIT_RST;
         failure_window_ff <= FAILURE_WINDOW_RST;
         backoff_ff        <= BACKOFF_RST;
         healthy_reset_ff  <= HEALTHY_RESET_RST;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         oldest_ff      <= oldest_in;
         ready_time_ff  <= ready_time_in;
         ready_valid_ff <= ready_valid_in;
         restart_at_ff  <= restart_at_in;
         live_boot_ff   <= live_boot_in;
         supp_ff        <= supp_in;
         supp_sess_ff   <= supp_sess_in;
         supp_boot_ff   <= supp_boot_in;
         rd_i_ff        <= rd_i_in;
         kept_ff        <= kept_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            // writes to the init suppression indices are accepted but stored nowhere
            unique case (csr_type'(csr_index))
               CSR_RESTART_DELAY:  restart_delay_ff  <= csr_wdata[CFG_W-1:0];
               CSR_FAILURE_LIMIT:  failure_limit_ff  <= csr_wdata[LIMIT_W-1:0];
               CSR_FAILURE_WINDOW: failure_window_ff <= csr_wdata[CFG_W-1:0];
               CSR_BACKOFF:        backoff_ff        <= csr_wdata[CFG_W-1:0];
               CSR_HEALTHY_RESET:  healthy_reset_ff  <= csr_wdata[CFG_W-1:0];
               CSR_INIT_SUPP, CSR_INIT_SUPP_SESS, CSR_INIT_SUPP_BOOT: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   // item payload and result flag
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= op_type'(req_op);
         now_ff   <= req_time_now[TW-1:0];
         sess_ff  <= req_session;
         boot_ff  <= req_boot_epoch;
         clean_ff <= req_clean_exit;
      end
      launch_ff <= launch_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_phase            = phase_ff;
   assign rsp_start_request    = launch_ff;
   assign rsp_restart_time     = TIME_W'(restart_at_ff);
   assign rsp_supp_active      = supp_ff;
   assign rsp_supp_session_out = supp_sess_ff;
   assign rsp_supp_boot_out    = supp_boot_ff;

endmodule
